FILE: design/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants of the LRU page replacement table
// Frame count, field widths, the search record that walks the cell row and
// the update word broadcast to the cells.
// ----------------------------------------------------------------------------
package lpr_pkg;

  // built frame count and page tag width
  localparam int unsigned FRAMES    = 16;
  localparam int unsigned PAGE_BITS = 16;

  // fixed field widths of the stream and config ports and of the use stamp
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned PAGE_W  = 16;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned FCNT_W  = 32;

  // derived widths
  localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CNT_W = $clog2(FRAMES + 1);
  localparam int unsigned CMP_W = (CFG_W > CNT_W) ? CFG_W : CNT_W;

  localparam logic [CFG_W-1:0]   FRAMES_RST = CFG_W'(4);
  localparam logic [STAMP_W-1:0] STAMP_MAX  = '1;
  localparam logic [FCNT_W-1:0]  FCNT_MAX   = '1;

  // search record handed from cell to cell
  typedef struct packed {
    logic                 tok;        // record is live in this stage
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic                 empty;
    logic [IDX_W-1:0]     empty_idx;
    logic                 has_min;
    logic [IDX_W-1:0]     min_idx;
    logic [STAMP_W-1:0]   min_stamp;
    logic [PAGE_BITS-1:0] min_page;
  } search_t;

  // frame update broadcast to all cells
  typedef struct packed {
    logic                 we;         // write stamp of frame idx
    logic                 fill;       // also load page and set valid
    logic [IDX_W-1:0]     idx;
    logic [PAGE_BITS-1:0] page;
    logic [STAMP_W-1:0]   stamp;
  } update_t;

endpackage

FILE: design/lpr_cell.sv
// ----------------------------------------------------------------------------
// lpr_cell: one frame of the LRU table
// Holds one page tag, its valid bit and its use stamp, and folds its frame
// into the search record that passes through it one stage per cycle.
// ----------------------------------------------------------------------------
module lpr_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lpr_pkg::IDX_W-1:0]     idx_i,      // position in the row
  input  logic [lpr_pkg::CNT_W-1:0]     n_i,        // frames in effect
  input  logic [lpr_pkg::PAGE_BITS-1:0] query_i,    // page being looked up
  input  logic                          clr_i,      // drop all frames
  input  lpr_pkg::update_t              upd_i,
  input  lpr_pkg::search_t              carry_i,
  output lpr_pkg::search_t              carry_o
);

  logic [lpr_pkg::PAGE_BITS-1:0] page_q;
  logic                          valid_q;
  logic [lpr_pkg::STAMP_W-1:0]   stamp_q;
  logic                          tok_q;
  lpr_pkg::search_t              rec_q, rec_d;
  logic                          active;
  logic                          sel;

  assign active = (lpr_pkg::CNT_W'(idx_i) < n_i);
  assign sel    = upd_i.we && (upd_i.idx == idx_i);

  // frame valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clr_i) begin
      valid_q <= 1'b0;
    end else if (sel && upd_i.fill) begin
      valid_q <= 1'b1;
    end
  end

  // frame tag and use stamp
  always_ff @(posedge clk_i) begin
    if (sel) begin
      stamp_q <= upd_i.stamp;
      if (upd_i.fill) begin
        page_q <= upd_i.page;
      end
    end
  end

  // fold this frame into the passing record
  always_comb begin
    rec_d = carry_i;
    if (active) begin
      if (!carry_i.hit && valid_q && (page_q == query_i)) begin
        rec_d.hit     = 1'b1;
        rec_d.hit_idx = idx_i;
      end
      if (!carry_i.empty && !valid_q) begin
        rec_d.empty     = 1'b1;
        rec_d.empty_idx = idx_i;
      end
      // strict compare keeps the lowest index on ties
      if (!carry_i.has_min || (stamp_q < carry_i.min_stamp)) begin
        rec_d.has_min   = 1'b1;
        rec_d.min_idx   = idx_i;
        rec_d.min_stamp = stamp_q;
        rec_d.min_page  = page_q;
      end
    end
  end

  // token moves every cycle, record loads only with the token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= carry_i.tok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (carry_i.tok) begin
      rec_q <= rec_d;
    end
  end

  always_comb begin
    carry_o     = rec_q;
    carry_o.tok = tok_q;
  end

endmodule

FILE: design/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement: fully associative LRU frame table
// A row of frame cells is searched by a record that walks the row one cell
// per cycle; the outcome is written back to one frame and reported.
// ----------------------------------------------------------------------------
//  channel      direction  payload
//  s_axis       in         tdata: page_number; tuser: start_new
//  m_axis       out        tdata: slot, evicted_page, fault_count;
//                          tuser: hit, evicted_valid
//  cfg          in         frames_in_use
//
// After the input transfer a launch register starts the search record, the
// record walks the cell row, the sequencer sees it leave the last cell, and
// the outcome is written back and registered as the result. The next input
// is taken once the sequencer is back in idle after that write-back.
// A result not yet taken holds the next write-back until it leaves.
// Reset empties every frame and sets frames_in_use to 4.
// ----------------------------------------------------------------------------
module lru_page_replacement (
  input  logic        clk_i,
  input  logic        rst_ni,
  // access in: tdata[15:0] page_number
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,
  // tuser[0] start_new
  input  logic [0:0]  s_axis_tuser_i,
  // result out
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata[3:0] slot, [19:4] evicted_page, [51:20] fault_count, [55:52] zero
  output logic [55:0] m_axis_tdata_o,
  // tuser[0] hit, [1] evicted_valid
  output logic [1:0]  m_axis_tuser_o,
  // frame count register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                           state_q, state_d;
  logic                                 launch_q;
  logic [lpr_pkg::CFG_W-1:0]            frames_q;
  logic [lpr_pkg::PAGE_BITS-1:0]        query_q;
  logic [lpr_pkg::STAMP_W-1:0]          clock_q;
  logic [lpr_pkg::FCNT_W-1:0]           faults_q;
  logic                                 out_valid_q;
  logic [55:0]                          out_data_q;
  logic [1:0]                           out_user_q;

  logic                                 in_xfer;
  logic                                 clr;
  logic                                 out_free;
  logic                                 finish;
  logic [lpr_pkg::CNT_W-1:0]            n_eff;
  logic [31:0]                          page_wide;
  lpr_pkg::search_t                     chain [lpr_pkg::FRAMES+1];
  lpr_pkg::search_t                     res;
  lpr_pkg::update_t                     upd;
  logic [lpr_pkg::STAMP_W-1:0]          clock_nx;
  logic [lpr_pkg::FCNT_W-1:0]           faults_nx;
  logic [lpr_pkg::IDX_W-1:0]            pos;
  logic                                 ev_valid;
  logic [31:0]                          ev_page_wide;
  logic [31:0]                          pos_wide;

  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign clr             = in_xfer && s_axis_tuser_i[0];
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign finish          = (state_q == S_DONE) && out_free;
  assign page_wide       = 32'(s_axis_tdata_i);

  // clamp the frame count into 1..FRAMES
  always_comb begin
    if (frames_q == '0) begin
      n_eff = lpr_pkg::CNT_W'(1);
    end else if (lpr_pkg::CMP_W'(frames_q) > lpr_pkg::CMP_W'(lpr_pkg::FRAMES)) begin
      n_eff = lpr_pkg::CNT_W'(lpr_pkg::FRAMES);
    end else begin
      n_eff = lpr_pkg::CNT_W'(frames_q);
    end
  end

  // frame count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= lpr_pkg::FRAMES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      frames_q <= cfg_data_i;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_xfer) state_d = S_RUN;
      S_RUN:  if (chain[lpr_pkg::FRAMES].tok) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      launch_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= in_xfer;
    end
  end

  // query tag capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      query_q <= page_wide[lpr_pkg::PAGE_BITS-1:0];
    end
  end

  // empty search record enters the first cell
  always_comb begin
    chain[0]     = '0;
    chain[0].tok = launch_q;
  end

  // cell row
  for (genvar k = 0; k < lpr_pkg::FRAMES; k++) begin : g_cell
    lpr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (lpr_pkg::IDX_W'(k)),
      .n_i     (n_eff),
      .query_i (query_q),
      .clr_i   (clr),
      .upd_i   (upd),
      .carry_i (chain[k]),
      .carry_o (chain[k+1])
    );
  end

  // pick the frame from the finished record
  assign res      = chain[lpr_pkg::FRAMES];
  assign clock_nx = (clock_q == lpr_pkg::STAMP_MAX) ? clock_q : clock_q + 1'b1;

  always_comb begin
    ev_valid  = 1'b0;
    faults_nx = faults_q;
    if (res.hit) begin
      pos = res.hit_idx;
    end else if (res.empty) begin
      pos = res.empty_idx;
    end else begin
      pos      = res.min_idx;
      ev_valid = 1'b1;
    end
    if (!res.hit && (faults_q != lpr_pkg::FCNT_MAX)) begin
      faults_nx = faults_q + 1'b1;
    end
  end

  assign ev_page_wide = ev_valid ? 32'(res.min_page) : 32'd0;
  assign pos_wide     = 32'(pos);

  // write-back to the chosen frame
  always_comb begin
    upd.we    = finish;
    upd.fill  = !res.hit;
    upd.idx   = pos;
    upd.page  = query_q;
    upd.stamp = clock_nx;
  end

  // access clock and fault count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q  <= '0;
      faults_q <= '0;
    end else if (clr) begin
      clock_q  <= '0;
      faults_q <= '0;
    end else if (finish) begin
      clock_q  <= clock_nx;
      faults_q <= faults_nx;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_data_q <= {4'd0, faults_nx, ev_page_wide[15:0], pos_wide[3:0]};
      out_user_q <= {ev_valid, res.hit};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

FILE: design/lpr_checker.sv
// ----------------------------------------------------------------------------
// lpr_checker: port-level checks of the LRU page replacement table
// Watches the stream ports for one-at-a-time handling and result coherence.
// ----------------------------------------------------------------------------
module lpr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [55:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // one access in flight: no transfer in the cycle after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while an access is in flight");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> !m_axis_tuser_o[1])
    else $error("eviction reported on a hit");

  // evicted page reads zero when nothing was replaced
  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[1] |-> (m_axis_tdata_o[19:4] == 16'd0))
    else $error("evicted page nonzero without eviction");

  // a fault always has a nonzero fault count
  a_fault_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> (m_axis_tdata_o[51:20] != 32'd0))
    else $error("fault reported with zero fault count");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

FILE: tb/tb_lru_page_replacement.sv
// ----------------------------------------------------------------------------
// tb_lru_page_replacement: self-checking bench of the LRU frame table
// A directed table walks reset, fill, hit, eviction, clear, frame count
// extremes and count changes in mid run. Random phases follow, each under
// its own frame count, with hot page pools and random stalls on both sides.
// Each result is checked field by field against a typed row or a local model.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = lpr_pkg::FRAMES + 8;
  localparam int unsigned NUM_PHASES     = 12;
  localparam int unsigned PHASE_ITEMS    = 145;
  localparam int unsigned DIR_N          = 20;

  // one result as the block reports it
  typedef struct packed {
    logic                         hit;
    logic [lpr_pkg::SLOT_W-1:0]   slot;
    logic                         ev_valid;
    logic [lpr_pkg::PAGE_W-1:0]   ev_page;
    logic [lpr_pkg::FCNT_W-1:0]   faults;
  } lru_result_t;

  // one row of the directed table
  typedef struct packed {
    logic                         cfg_wr;
    logic [lpr_pkg::CFG_W-1:0]    cfg_val;
    logic [lpr_pkg::PAGE_W-1:0]   page;
    logic                         start;
    logic                         typed;
    lru_result_t                  res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;
  logic [0:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [55:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i;

  // model state
  logic [lpr_pkg::PAGE_BITS-1:0] mdl_page  [lpr_pkg::FRAMES];
  logic                          mdl_valid [lpr_pkg::FRAMES];
  logic [lpr_pkg::STAMP_W-1:0]   mdl_stamp [lpr_pkg::FRAMES];
  logic [lpr_pkg::STAMP_W-1:0]   mdl_clock;
  logic [lpr_pkg::FCNT_W-1:0]    mdl_faults;
  logic [lpr_pkg::CFG_W-1:0]     mdl_frames;

  lru_result_t access_outcomes[$];
  dir_row_t    dir_rows [DIR_N];

  int unsigned err_count;
  int unsigned idle_cycles;
  int unsigned rx_gap;
  int unsigned rx_pct;
  int unsigned tx_pct;
  bit          quiet;

  lru_page_replacement DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // empty every frame, stamp, clock and fault count
  function automatic void table_clear();
    for (int k = 0; k < lpr_pkg::FRAMES; k++) begin
      mdl_page[k]  = '0;
      mdl_valid[k] = 1'b0;
      mdl_stamp[k] = '0;
    end
    mdl_clock  = '0;
    mdl_faults = '0;
  endfunction

  // one access against the model table
  function automatic lru_result_t lru_lookup(logic [lpr_pkg::PAGE_W-1:0] page, logic start);
    lru_result_t                   r;
    int unsigned                   n;
    int unsigned                   pos;
    bit                            found;
    bit                            empty;
    logic [lpr_pkg::PAGE_BITS-1:0] tag;
    r     = '0;
    pos   = 0;
    found = 1'b0;
    empty = 1'b0;
    tag   = page[lpr_pkg::PAGE_BITS-1:0];
    if (start) table_clear();
    // out of range frame counts clamp to 1 and FRAMES
    n = mdl_frames;
    if (n < 1) n = 1;
    if (n > lpr_pkg::FRAMES) n = lpr_pkg::FRAMES;
    if (mdl_clock != lpr_pkg::STAMP_MAX) mdl_clock = mdl_clock + 1'b1;
    // lowest matching frame wins
    for (int k = 0; k < n; k++) begin
      if (!found && mdl_valid[k] && mdl_page[k] == tag) begin
        pos   = k;
        found = 1'b1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
    end else begin
      for (int k = 0; k < n; k++) begin
        if (!empty && !mdl_valid[k]) begin
          pos   = k;
          empty = 1'b1;
        end
      end
      // oldest stamp, lowest index on ties
      if (!empty) begin
        pos = 0;
        for (int k = 1; k < n; k++) begin
          if (mdl_stamp[k] < mdl_stamp[pos]) pos = k;
        end
        r.ev_valid = 1'b1;
        r.ev_page  = lpr_pkg::PAGE_W'(mdl_page[pos]);
      end
      mdl_page[pos]  = tag;
      mdl_valid[pos] = 1'b1;
      if (mdl_faults != lpr_pkg::FCNT_MAX) mdl_faults = mdl_faults + 1'b1;
    end
    mdl_stamp[pos] = mdl_clock;
    r.slot   = lpr_pkg::SLOT_W'(pos);
    r.faults = mdl_faults;
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // hand one access to the block and record what it should report
  task automatic send_access(logic [lpr_pkg::PAGE_W-1:0] page, logic start, logic typed,
                             lru_result_t typed_res);
    lru_result_t pred;
    s_axis_tdata_i  <= page;
    s_axis_tuser_i  <= start;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = lru_lookup(page, start);
    access_outcomes.push_back(typed ? typed_res : pred);
  endtask

  // random sender gap after a transfer
  task automatic sender_gap();
    if (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // hold off until every result is back and the pipeline has drained
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (access_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_frames(logic [lpr_pkg::CFG_W-1:0] val);
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mdl_frames = val;
  endtask

  // result side: random stall bursts
  always @(posedge clk_i) begin
    if (rx_gap != 0) begin
      rx_gap--;
    end else if (!quiet && rx_pct != 0 && $urandom_range(0, 99) < rx_pct) begin
      rx_gap = $urandom_range(1, 5);
    end
    m_axis_tready_i <= (rx_gap == 0);
  end

  // result checker
  always @(posedge clk_i) begin
    lru_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (access_outcomes.size() == 0) begin
        flag_mismatch("unexpected result", m_axis_tdata_o[31:0], 32'h0);
      end else begin
        want = access_outcomes.pop_front();
        if (m_axis_tuser_o[0] !== want.hit)
          flag_mismatch("hit", 32'(m_axis_tuser_o[0]), 32'(want.hit));
        if (m_axis_tuser_o[1] !== want.ev_valid)
          flag_mismatch("evicted_valid", 32'(m_axis_tuser_o[1]), 32'(want.ev_valid));
        if (m_axis_tdata_o[3:0] !== want.slot)
          flag_mismatch("slot", 32'(m_axis_tdata_o[3:0]), 32'(want.slot));
        if (m_axis_tdata_o[19:4] !== want.ev_page)
          flag_mismatch("evicted_page", 32'(m_axis_tdata_o[19:4]), 32'(want.ev_page));
        if (m_axis_tdata_o[51:20] !== want.faults)
          flag_mismatch("fault_count", m_axis_tdata_o[51:20], want.faults);
        if (m_axis_tdata_o[55:52] !== 4'h0)
          flag_mismatch("tdata padding", 32'(m_axis_tdata_o[55:52]), 32'h0);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [lpr_pkg::CFG_W-1:0]  fr;
    logic [lpr_pkg::PAGE_W-1:0] base;
    logic [lpr_pkg::PAGE_W-1:0] pg;
    logic                       st;
    int unsigned                eff;
    int unsigned                span;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    m_axis_tready_i = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    rst_ni          = 1'b0;
    err_count       = 0;
    idle_cycles     = 0;
    rx_gap          = 0;
    rx_pct          = 0;
    tx_pct          = 0;
    quiet           = 1'b0;
    table_clear();
    mdl_frames = lpr_pkg::FRAMES_RST;

    // cfg_wr, cfg_val, page, start, typed, {hit, slot, ev_valid, ev_page, faults}
    dir_rows = '{
      // fill from reset with four frames
      '{1'b1, 5'd4,  16'h0000, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}},
      '{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 32'd2}},
      '{1'b0, 5'd0,  16'h0000, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd2}},
      '{1'b0, 5'd0,  16'h1234, 1'b0, 1'b1, '{1'b0, 4'd2, 1'b0, 16'h0000, 32'd3}},
      '{1'b0, 5'd0,  16'h5678, 1'b0, 1'b1, '{1'b0, 4'd3, 1'b0, 16'h0000, 32'd4}},
      // full table, least recent is frame 1
      '{1'b0, 5'd0,  16'hABCD, 1'b0, 1'b1, '{1'b0, 4'd1, 1'b1, 16'hFFFF, 32'd5}},
      // start of a new reference string
      '{1'b0, 5'd0,  16'hFFFF, 1'b1, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}},
      // frame count zero acts as one
      '{1'b1, 5'd0,  16'h0001, 1'b0, 1'b1, '{1'b0, 4'd0, 1'b1, 16'hFFFF, 32'd2}},
      '{1'b0, 5'd0,  16'h0001, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd2}},
      // frame count above the built size acts as all frames
      '{1'b1, 5'd31, 16'h0002, 1'b0, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 32'd3}},
      '{1'b0, 5'd0,  16'hFFFF, 1'b0, 1'b1, '{1'b0, 4'd2, 1'b0, 16'h0000, 32'd4}},
      // shrink: frame 2 is hidden, page lands again in a low frame
      '{1'b1, 5'd2,  16'hFFFF, 1'b0, 1'b0, '0},
      // grow back: two matching frames, lowest one hits
      '{1'b1, 5'd16, 16'hFFFF, 1'b0, 1'b0, '0},
      '{1'b1, 5'd17, 16'h8000, 1'b0, 1'b0, '0},
      '{1'b1, 5'd16, 16'h7FFF, 1'b1, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}},
      '{1'b0, 5'd0,  16'h7FFF, 1'b1, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}},
      '{1'b0, 5'd0,  16'h7FFF, 1'b0, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd1}},
      '{1'b1, 5'd3,  16'hAAAA, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  16'h5555, 1'b0, 1'b0, '0},
      '{1'b0, 5'd0,  16'h0F0F, 1'b0, 1'b0, '0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part with light stalls
    tx_pct = 30;
    rx_pct = 30;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_wr) begin
        settle();
        write_frames(dir_rows[i].cfg_val);
      end
      send_access(dir_rows[i].page, dir_rows[i].start, dir_rows[i].typed, dir_rows[i].res);
      sender_gap();
    end

    // random phases, each under one frame count; the last one runs flat out
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      quiet = (ph == NUM_PHASES - 1);
      case ($urandom_range(0, 7))
        0:       fr = 5'd0;
        1:       fr = 5'd1;
        2:       fr = 5'd16;
        3:       fr = 5'd31;
        4:       fr = lpr_pkg::CFG_W'($urandom_range(17, 31));
        5, 6:    fr = lpr_pkg::CFG_W'($urandom_range(1, 5));
        default: fr = lpr_pkg::CFG_W'($urandom_range(1, 16));
      endcase
      write_frames(fr);
      case ($urandom_range(0, 2))
        0:       tx_pct = 0;
        1:       tx_pct = 20;
        default: tx_pct = 50;
      endcase
      rx_pct = $urandom_range(0, 2) * 25;
      if (quiet) begin
        tx_pct = 0;
        rx_pct = 0;
      end
      eff  = (fr < 1) ? 1 : (fr > lpr_pkg::FRAMES) ? lpr_pkg::FRAMES : fr;
      span = eff + $urandom_range(0, eff + 2);
      base = lpr_pkg::PAGE_W'($urandom);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // hot pool around a random base, some fully random pages
        if ($urandom_range(0, 9) == 0)
          pg = lpr_pkg::PAGE_W'($urandom);
        else
          pg = base ^ lpr_pkg::PAGE_W'($urandom_range(0, span));
        if (k == 0)
          st = $urandom_range(0, 1);
        else
          st = ($urandom_range(0, 49) == 0);
        send_access(pg, st, 1'b0, '0);
        sender_gap();
      end
    end

    // drain and finish
    settle();
    if (err_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
